### hw/rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants of the interpolated sine oscillator.
// ----------------------------------------------------------------------------
package isc_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_INCREMENT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_MOD_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SATURATION       = 2'd2;

   // saturation amount 1.0 and its clamp value 0.99, Q1.16
   localparam logic [16:0] SAT_ONE   = 17'd65536;
   localparam logic [16:0] SAT_CLAMP = 17'd64881;

   // controller to datapath commands
   typedef struct packed {
      logic capture;     // take request fields and split phase
      logic rd_next;     // table address is index plus one
      logic ld_v1;       // first table entry is on the read data
      logic phase_mul;   // increment times pitch ratio
      logic phase_add;   // advance phase
      logic interp;      // linear interpolation
      logic sat_mul;     // magnitude and shaper product
      logic div_load;    // set up shaper division
      logic div_step;    // one quotient bit
      logic gain_mul;    // gain product
      logic out_load;    // load result registers
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic sat_on;      // shaper enabled
   } sts_type;

endpackage

### hw/rtl/isc_ctrl.sv
// ----------------------------------------------------------------------------
// isc_ctrl
// Sequencer for one sample: table reads, interpolation, shaper divide, gain.
// ----------------------------------------------------------------------------
module isc_ctrl #(
   parameter int QUOT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  isc_pkg::sts_type sts,
   output isc_pkg::cmd_type cmd
);
   import isc_pkg::*;

   localparam int CNT_W = $clog2(QUOT_BITS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD0  = 3'd1;
   localparam logic [2:0] S_RD1  = 3'd2;
   localparam logic [2:0] S_INTP = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_DSET = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             gain_ff, gain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !(rsp_valid_ff && rsp_stall);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      gain_in  = 1'b0;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_RD0;
            end
         end
         S_RD0: begin
            cmd.phase_mul = 1'b1;
            state_in      = S_RD1;
         end
         S_RD1: begin
            cmd.rd_next   = 1'b1;
            cmd.ld_v1     = 1'b1;
            cmd.phase_add = 1'b1;
            state_in      = S_INTP;
         end
         S_INTP: begin
            cmd.interp = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            cmd.sat_mul = 1'b1;
            if (sts.sat_on) begin
               state_in = S_DSET;
            end else begin
               gain_in  = 1'b1;
               state_in = S_FIN;
            end
         end
         S_DSET: begin
            cmd.div_load = 1'b1;
            cnt_in       = CNT_W'(QUOT_BITS - 1);
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               gain_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FIN: begin
            // gain product is taken on entry here, before the result load
            cmd.gain_mul = gain_ff;
            if (!gain_ff && out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         gain_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/isc_dp.sv
// ----------------------------------------------------------------------------
// isc_dp
// Oscillator datapath: phase, sine table, interpolator, shaper, gain stage.
// ----------------------------------------------------------------------------
module isc_dp #(
   parameter int TABLE_BITS  = 11,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  isc_pkg::cmd_type                  cmd,
   output isc_pkg::sts_type                  sts,
   input  logic                              csr_write,
   input  logic [isc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_data,
   input  logic [19:0]                       req_pitch_ratio,
   input  logic [15:0]                       req_gain,
   input  logic                              req_block_end,
   output logic signed [15:0]                rsp_sample_out,
   output logic                              rsp_end_of_block
);
   import isc_pkg::*;

   localparam int TS    = 1 << TABLE_BITS;
   localparam int FRAC  = 32 - TABLE_BITS;
   localparam int SB    = SAMPLE_BITS;
   localparam int PB    = SAMPLE_BITS - 1;
   localparam int QW    = SAMPLE_BITS;
   localparam int AW    = SB + FRAC + 3;
   localparam int SAW   = SB + 17;
   localparam int DW    = 2 * SB + 20;
   localparam int GW    = SB + 16;

   typedef logic signed [SB-1:0] rom_arr_type [TS];

   // one-period sine table, Q30 Taylor series on the first quarter
   function automatic rom_arr_type build_rom();
      rom_arr_type r;
      logic [63:0] x, x2, t, s, e, amp;
      logic [TABLE_BITS-1:0] a0, a1, a2, a3;
      amp = (64'd1 << PB) - 64'd1;
      for (int k = 0; k <= TS / 4; k++) begin
         x  = (64'(k) * 64'd6746518852) >> TABLE_BITS;
         x2 = (x * x) >> 30;
         t  = 64'd1 << 30;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd156;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
         t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
         s  = (x * t) >> 30;
         e  = (s * amp + (64'd1 << 29)) >> 30;
         a0 = TABLE_BITS'(k);
         a1 = TABLE_BITS'(TS / 2 - k);
         a2 = TABLE_BITS'(TS / 2 + k);
         a3 = TABLE_BITS'(TS - k);
         r[a0] = SB'(e);
         r[a1] = SB'(e);
         r[a2] = SB'(-e);
         r[a3] = SB'(-e);
      end
      return r;
   endfunction

   localparam rom_arr_type ROM_DATA = build_rom();

   // configuration and state
   logic [31:0]            pinc_ff;
   logic                   pme_ff;
   logic [16:0]            sat_ff;
   logic [31:0]            phase_ff;
   logic [51:0]            pprod_ff;
   logic [19:0]            ratio_ff;
   logic [15:0]            gain_ff;
   logic                   bend_ff;
   logic [TABLE_BITS-1:0]  idx_ff;
   logic [FRAC-1:0]        alpha_ff;
   logic [TABLE_BITS-1:0]  rom_addr;
   logic signed [SB-1:0]   rom_q_ff;
   logic signed [SB-1:0]   v1_ff;
   logic signed [SB-1:0]   x_ff;
   logic [SB-1:0]          ax_ff;
   logic                   neg_ff;
   logic [SAW-1:0]         sa_ff;
   logic [DW-1:0]          rem_ff;
   logic [DW-1:0]          dsh_ff;
   logic [QW-1:0]          q_ff;
   logic [GW-1:0]          gm_ff;
   logic signed [15:0]     sample_ff;
   logic                   eob_ff;

   logic [16:0]            s_eff;
   logic signed [SB:0]     diff;
   logic signed [FRAC:0]   alpha_s;
   logic signed [AW-1:0]   acc;
   logic [SB-1:0]          ax;
   logic [DW-1:0]          num, den;
   logic [31:0]            inc;
   logic [SB-1:0]          ymag;
   logic [GW:0]            mag;
   logic [15:0]            res;

   assign s_eff      = (sat_ff >= SAT_ONE) ? SAT_CLAMP : sat_ff;
   assign sts.sat_on = (sat_ff != '0);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pinc_ff <= '0;
         pme_ff  <= 1'b0;
         sat_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PHASE_INCREMENT:  pinc_ff <= csr_data;
            CSR_PITCH_MOD_ENABLE: pme_ff  <= csr_data[0];
            CSR_SATURATION:       sat_ff  <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   // phase accumulator
   assign inc = pme_ff ? pprod_ff[47:16] : pinc_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (cmd.phase_add) begin
         phase_ff <= phase_ff + inc;
      end
   end

   // request capture and increment product
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ratio_ff <= req_pitch_ratio;
         gain_ff  <= req_gain;
         bend_ff  <= req_block_end;
         idx_ff   <= phase_ff[31 -: TABLE_BITS];
         alpha_ff <= phase_ff[FRAC-1:0];
      end
      if (cmd.phase_mul) pprod_ff <= pinc_ff * ratio_ff;
   end

   // sine table, registered read
   assign rom_addr = cmd.rd_next ? idx_ff + 1'b1 : idx_ff;
   always_ff @(posedge clock) begin
      rom_q_ff <= ROM_DATA[rom_addr];
      if (cmd.ld_v1) v1_ff <= rom_q_ff;
   end

   // interpolation: v1 + (v2 - v1) * alpha, rounded half up
   assign diff    = (SB+1)'(rom_q_ff) - (SB+1)'(v1_ff);
   assign alpha_s = {1'b0, alpha_ff};
   assign acc     = (AW'(v1_ff) <<< FRAC) + (AW'(diff) * AW'(alpha_s))
                  + (AW'(1) <<< (FRAC - 1));
   always_ff @(posedge clock) begin
      if (cmd.interp) x_ff <= SB'(acc >>> FRAC);
   end

   // shaper: magnitude and s*|x|
   assign ax = x_ff[SB-1] ? SB'(-x_ff) : SB'(x_ff);
   always_ff @(posedge clock) begin
      if (cmd.sat_mul) begin
         ax_ff  <= ax;
         neg_ff <= x_ff[SB-1];
         sa_ff  <= SAW'(s_eff) * SAW'(ax);
      end
   end

   // shaper division, one quotient bit per cycle, rounded to nearest
   assign num = (((DW'(ax_ff) << 16) + DW'(sa_ff)) << PB);
   assign den = (DW'(17'(SAT_ONE - s_eff)) << PB) + (DW'(sa_ff) << 1);
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= num + (den >> 1);
         dsh_ff <= den << (QW - 1);
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff <= rem_ff - dsh_ff;
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[QW-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   // gain product
   assign ymag = sts.sat_on ? q_ff : ax_ff;
   always_ff @(posedge clock) begin
      if (cmd.gain_mul) gm_ff <= ymag * gain_ff;
   end

   // rounding and saturation to Q1.15
   assign mag = ((GW+1)'(gm_ff) + ((GW+1)'(1) << (PB - 1))) >> PB;
   always_comb begin
      if (neg_ff) begin
         res = (mag > (GW+1)'(32768)) ? 16'h8000 : 16'(-mag);
      end else begin
         res = (mag > (GW+1)'(32767)) ? 16'h7fff : mag[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         sample_ff <= res;
         eob_ff    <= bend_ff;
      end
   end

   assign rsp_sample_out   = sample_ff;
   assign rsp_end_of_block = eob_ff;

endmodule

### hw/rtl/interpolated_sine_oscillator.sv
// A request passes the table reads, interpolation and shaper product; with the shaper on,
// the restoring divider of the shaper runs before the gain product and the result load.
// The next request is taken once the result is loaded, while that result may still
// wait in the output register. A stalled result holds the sequencer in its last state.
// Reset (synchronous, active high) clears phase, configuration and handshake state.
// ----------------------------------------------------------------------------
// interpolated_sine_oscillator
// Wavetable sine oscillator with linear interpolation, soft shaper and gain.
// ----------------------------------------------------------------------------
module interpolated_sine_oscillator #(
   parameter int TABLE_BITS  = 11,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [isc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [19:0]                     req_pitch_ratio,
   input  logic [15:0]                     req_gain,
   input  logic                            req_block_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [15:0]              rsp_sample_out,
   output logic                            rsp_end_of_block
);
   import isc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   isc_ctrl #(
      .QUOT_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   isc_dp #(
      .TABLE_BITS  (TABLE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_pitch_ratio  (req_pitch_ratio),
      .req_gain         (req_gain),
      .req_block_end    (req_block_end),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_end_of_block (rsp_end_of_block)
   );

`ifndef ASSERT_OFF
   // an accepted request keeps the input stalled while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while busy");

   // a new result appears only as the sequencer returns to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result raised while busy");
`endif

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives sample ticks into the sine oscillator and checks every output sample
// against a bit-exact predictor: table interpolation, soft shaper, gain and
// phase advance, over several increment, pitch and shaper settings.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import isc_pkg::*;

   localparam int TBITS = 11;
   localparam int FRAC = 32 - TBITS;
   localparam int TSIZE = 1 << TBITS;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int NUM_RANDOM = 1500;

   typedef struct packed {
      logic [19:0] pitch_ratio;
      logic [15:0] gain;
      logic        block_end;
   } tick_t;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               eob;
   } sample_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [19:0] req_pitch_ratio = '0;
   logic [15:0] req_gain = '0;
   logic req_block_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample_out;
   logic rsp_end_of_block;

   interpolated_sine_oscillator dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // sine table and oscillator state of the predictor
   longint sine_rom [TSIZE];
   logic [31:0] osc_phase = '0;
   logic [31:0] osc_inc = '0;
   logic        osc_pitch_on = 1'b0;
   logic [16:0] osc_sat = '0;

   tick_t   pending_ticks[$];
   sample_t expected_samples[$];
   int errors = 0;
   int n_checked = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit hold_sender = 1'b0;
   bit long_hold = 1'b0;
   bit stim_done = 1'b0;
   bit req_taken = 1'b0;

   function automatic void build_sine_rom();
      longint unsigned divs[6] = '{156, 110, 72, 42, 20, 6};
      longint unsigned x, x2, t, s, amp, q30;
      longint e;
      amp = (64'd1 << 15) - 1;
      q30 = 64'd1 << 30;
      for (int k = 0; k <= TSIZE / 4; k++) begin
         x = (longint'(k) * 64'd6746518852) >> TBITS;
         x2 = (x * x) >> 30;
         t = q30;
         for (int i = 0; i < 6; i++) t = q30 - ((x2 * t) >> 30) / divs[i];
         s = (x * t) >> 30;
         e = longint'((s * amp + (q30 >> 1)) >> 30);
         sine_rom[k % TSIZE] = e;
         sine_rom[(TSIZE / 2 - k) % TSIZE] = e;
         sine_rom[(TSIZE / 2 + k) % TSIZE] = -e;
         sine_rom[(TSIZE - k) % TSIZE] = -e;
      end
   endfunction

   // one sample tick: output from the current phase, then phase advance
   function automatic sample_t next_sample(tick_t tk);
      sample_t r;
      int unsigned idx;
      longint alpha, acc, x, y, ax, s, num, den, q, mag;
      bit neg;
      idx = osc_phase >> FRAC;
      alpha = longint'(osc_phase & ((32'd1 << FRAC) - 1));
      acc = sine_rom[idx] * ((64'sd1 <<< FRAC) - alpha)
          + sine_rom[(idx + 1) % TSIZE] * alpha;
      x = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;   // arithmetic shift = floor
      if (osc_sat != 0) begin
         s = (osc_sat >= SAT_ONE) ? longint'(SAT_CLAMP) : longint'(osc_sat);
         ax = (x < 0) ? -x : x;
         num = (65536 + s) * ax * 32768;
         den = (65536 - s) * 32768 + 2 * s * ax;
         q = (num + den / 2) / den;
         y = (x < 0) ? -q : q;
      end else begin
         y = x;
      end
      neg = (y < 0);
      mag = ((neg ? -y : y) * longint'(tk.gain) + 16384) >>> 15;
      if (neg) begin
         if (mag > 32768) mag = 32768;
         r.sample = 16'(-mag);
      end else begin
         if (mag > 32767) mag = 32767;
         r.sample = 16'(mag);
      end
      r.eob = tk.block_end;
      if (osc_pitch_on)
         osc_phase = osc_phase + 32'((64'(osc_inc) * 64'(tk.pitch_ratio)) >> 16);
      else
         osc_phase = osc_phase + osc_inc;
      return r;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_PHASE_INCREMENT:  osc_inc = val;
         CSR_PITCH_MOD_ENABLE: osc_pitch_on = val[0];
         CSR_SATURATION:       osc_sat = val[16:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() != 0 || expected_samples.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic tick_t rand_tick();
      tick_t t;
      case ($urandom_range(0, 9))
         0: t.gain = 16'd32768;
         1: t.gain = 16'($urandom_range(32769, 65535));
         2: t.gain = '0;
         default: t.gain = 16'($urandom_range(0, 32768));
      endcase
      t.pitch_ratio = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                    : 20'($urandom_range(0, 131072));
      t.block_end = ($urandom_range(0, 15) == 0);
      return t;
   endfunction

   // request accepted at the last rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   // driver: bursts with random gaps
   int gap_left = 0;
   int burst_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the request until it is taken
      end else begin
         if (req_valid) void'(pending_ticks.pop_front());
         if (hold_sender || pending_ticks.size() == 0) begin
            req_valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_pitch_ratio <= pending_ticks[0].pitch_ratio;
            req_gain <= pending_ticks[0].gain;
            req_block_end <= pending_ticks[0].block_end;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 20);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
            end
         end
      end
   end

   // receiver stall pattern, with a long hold counted here on request
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 200;
      if (long_hold && hold_left == 0) begin
         hold_left <= 500;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_phase < 80) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : ($urandom_range(0, 5) == 0);
   end

   // monitor: predict on accepted requests, check accepted samples
   always @(posedge clock) begin
      sample_t want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_samples.push_back(next_sample('{req_pitch_ratio, req_gain, req_block_end}));
         if (rsp_valid && !rsp_stall) begin
            n_checked++;
            if (expected_samples.size() == 0) begin
               errors++;
               $display("%t: unexpected sample %0d", $realtime, rsp_sample_out);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want.sample) begin
                  errors++;
                  $display("%t: sample_out expected %0d actual %0d", $realtime,
                           want.sample, rsp_sample_out);
               end
               if (rsp_end_of_block !== want.eob) begin
                  errors++;
                  $display("%t: end_of_block expected %0b actual %0b", $realtime,
                           want.eob, rsp_end_of_block);
               end
            end
         end
      end
   end

   // watchdog on cycles without any accepted handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || long_hold
          || hold_left > 0
          || (pending_ticks.size() == 0 && expected_samples.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("%t: no progress, watchdog expired", $realtime);
         $display("tb failed");
         $finish;
      end
   end

   task automatic run_phase(input logic [31:0] inc, input logic pm,
                            input logic [16:0] sat, input int n);
      write_csr(CSR_PHASE_INCREMENT, inc);
      write_csr(CSR_PITCH_MOD_ENABLE, {31'd0, pm});
      write_csr(CSR_SATURATION, {15'd0, sat});
      for (int i = 0; i < n; i++) pending_ticks.push_back(rand_tick());
      wait_drained();
   endtask

   initial begin
      build_sine_rom();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, shaper edge settings, wrap of the phase
      write_csr(CSR_PHASE_INCREMENT, 32'h0123_4567);
      write_csr(CSR_SATURATION, {15'd0, SAT_ONE});
      pending_ticks.push_back('{20'd0, 16'd32768, 1'b1});
      pending_ticks.push_back('{20'hFFFFF, 16'hFFFF, 1'b0});
      pending_ticks.push_back('{20'h10000, 16'd0, 1'b1});
      pending_ticks.push_back('{20'h55555, 16'hAAAA, 1'b0});
      pending_ticks.push_back('{20'hAAAAA, 16'h5555, 1'b1});
      wait_drained();
      write_csr(CSR_SATURATION, 32'h1FFFF);          // out of range, clamps
      write_csr(CSR_PHASE_INCREMENT, 32'hFFFF_FFFF);
      write_csr(CSR_PITCH_MOD_ENABLE, 32'd1);
      for (int i = 0; i < 10; i++) pending_ticks.push_back(rand_tick());
      wait_drained();

      // random phases over settings, extremes included
      run_phase(32'd0, 1'b0, 17'd0, 100);
      run_phase(32'h0040_0000, 1'b0, 17'd0, 200);
      run_phase(32'h0040_0000, 1'b1, 17'd0, 200);
      run_phase(32'($urandom), 1'b1, 17'd1, 150);
      run_phase(32'($urandom), 1'b0, 17'd32768, 200);
      run_phase(32'($urandom), 1'b1, 17'($urandom_range(1, 65535)), 200);
      run_phase(32'hFFFF_FFFF, 1'b0, SAT_ONE, 150);

      // long receiver hold while the sender keeps offering
      write_csr(CSR_SATURATION, 32'd0);
      hold_sender = 1'b0;
      for (int i = 0; i < 100; i++) pending_ticks.push_back(rand_tick());
      long_hold = 1'b1;
      wait (hold_left > 0);
      long_hold = 1'b0;
      wait (hold_left == 0);
      wait_drained();
      run_phase(32'($urandom), 1'b1, 17'($urandom_range(1, 65536)), 200);

      repeat (60) @(posedge clock);
      $display("covered %0d samples over %0d register settings, shaper on and off,",
               n_checked, 10);
      $display("pitch modulation on and off, long output stall and a full drain");
      if (errors == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end
endmodule
